FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/erci_pkg.sv
// types, constants and area lookup for the rho corrected isolation pipeline
package erci_pkg;

  localparam int NUM_BINS  = 7;
  localparam int QUO_W     = 16;
  localparam int NUM_W     = 28;
  localparam int DEN_W     = 26;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int FRONT_STAGES = 4;

  localparam logic [1:0] REG_CONE = 2'd0;
  localparam logic [1:0] REG_2012 = 2'd1;
  localparam logic [1:0] REG_SIM  = 2'd2;

  typedef logic [12:0] edge_tab_t [0:NUM_BINS-2];
  typedef logic [7:0]  area_tab_t [0:NUM_BINS-1];

  localparam edge_tab_t ETA_EDGES = '{13'd1000, 13'd1479, 13'd2000, 13'd2200,
                                      13'd2300, 13'd2400};
  localparam area_tab_t AREA_2012 = '{8'd130, 8'd140, 8'd70, 8'd90, 8'd110,
                                      8'd110, 8'd140};
  localparam area_tab_t AREA_SIM  = '{8'd110, 8'd130, 8'd89, 8'd130, 8'd150,
                                      8'd160, 8'd190};
  localparam area_tab_t AREA_DAT  = '{8'd100, 8'd120, 8'd85, 8'd110, 8'd120,
                                      8'd120, 8'd130};

  typedef struct packed {
    logic cone;
    logic y2012;
    logic sim;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        rho;
    logic signed [12:0] eta;
    logic [15:0]        pt;
    logic [15:0]        photon;
    logic [15:0]        neutral;
    logic [15:0]        charged;
  } item_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [3:0]       nbits;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             sat;
    logic             zero;
  } div_t;

  function automatic logic [12:0] abs_eta(input logic signed [12:0] e);
    logic [12:0] r;
    r = e[12] ? 13'(~e + 13'sd1) : 13'(e);
    return r;
  endfunction

  function automatic logic [7:0] area_lookup(input logic [12:0] ae, input cfg_t cfg);
    logic [2:0] bin;
    logic [7:0] a;
    bin = '0;
    for (int i = 0; i < NUM_BINS - 1; i++) begin
      if (ae >= ETA_EDGES[i]) bin = 3'(i + 1);
    end
    if (!cfg.cone) a = '0;
    else if (cfg.y2012) a = AREA_2012[bin];
    else if (cfg.sim) a = AREA_SIM[bin];
    else a = AREA_DAT[bin];
    return a;
  endfunction

endpackage

FILE: rtl/erci_front.sv
// front stages: area lookup, scaling products, numerator and range check
module erci_front (
  input  logic                                  clk,
  input  logic [erci_pkg::FRONT_STAGES-1:0]     load,
  input  erci_pkg::item_t                       din,
  input  erci_pkg::cfg_t                        cfg,
  output erci_pkg::div_t                        dout
);
  import erci_pkg::*;

  typedef struct packed {
    logic [15:0] charged;
    logic [16:0] np;
    logic [15:0] rho;
    logic [7:0]  area;
    logic [15:0] pt;
    logic        zero;
  } st0_t;

  typedef struct packed {
    logic [25:0]      chg_k;
    logic [26:0]      pos_k;
    logic [23:0]      sub;
    logic [DEN_W-1:0] den;
    logic             zero;
  } st1_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             zero;
  } st2_t;

  st0_t s0;
  st1_t s1;
  st2_t s2;
  logic [26:0] diff;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s0.charged <= din.charged;
      s0.np      <= {1'b0, din.neutral} + {1'b0, din.photon};
      s0.rho     <= din.rho;
      s0.area    <= area_lookup(abs_eta(din.eta), cfg);
      s0.pt      <= din.pt;
      s0.zero    <= (din.pt == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1.chg_k <= {10'd0, s0.charged} * 26'd1000;
      s1.pos_k <= {10'd0, s0.np} * 27'd1000;
      s1.sub   <= {8'd0, s0.rho} * {16'd0, s0.area};
      s1.den   <= {10'd0, s0.pt} * 26'd1000;
      s1.zero  <= s0.zero;
    end
  end

  assign diff = s1.pos_k - {3'd0, s1.sub};

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2.num  <= {2'd0, s1.chg_k} + ((s1.pos_k > {3'd0, s1.sub}) ? {1'b0, diff} : '0);
      s2.den  <= s1.den;
      s2.zero <= s1.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      dout.rem   <= {2'd0, s2.num[NUM_W-1:4]};
      dout.nbits <= s2.num[3:0];
      dout.den   <= s2.den;
      dout.quo   <= '0;
      dout.sat   <= !s2.zero && ({2'd0, s2.num} >= {s2.den, 4'd0});
      dout.zero  <= s2.zero;
    end
  end

endmodule

FILE: rtl/erci_div_stage.sv
// one divider stage, resolves two quotient bits by restoring division
module erci_div_stage (
  input  logic           clk,
  input  logic           load,
  input  erci_pkg::div_t din,
  output erci_pkg::div_t dout
);
  import erci_pkg::*;

  div_t nxt;
  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;

  always_comb begin
    nxt   = din;
    trial = '0;
    diff  = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial     = {nxt.rem, nxt.nbits[3]};
      nxt.nbits = {nxt.nbits[2:0], 1'b0};
      diff      = trial - {1'b0, nxt.den};
      if (trial >= {1'b0, nxt.den}) begin
        nxt.rem = diff[DEN_W-1:0];
        nxt.quo = {nxt.quo[QUO_W-2:0], 1'b1};
      end else begin
        nxt.rem = trial[DEN_W-1:0];
        nxt.quo = {nxt.quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) dout <= nxt;
  end

endmodule

FILE: rtl/electron_rho_corrected_isolation_top.sv
// throughput: one item per cycle while m_tready is high, each stage advances on its own when downstream has room
// the depth is set by 4 front stages and 8 divider stages of 2 quotient bits each
// reset: synchronous, clears all valid bits and loads register defaults cone 1, 2012 1, sim 0
module electron_rho_corrected_isolation_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // charged_iso, neutral_iso, photon_iso,
                                 // transverse_momentum, cluster_eta, event_density, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // relative_iso
  output logic [1:0]  m_tuser,   // saturated, zero_momentum
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);
  import erci_pkg::*;

  localparam int NS = FRONT_STAGES + DIV_STAGES;

  cfg_t            cfg;
  item_t           item;
  logic [NS-1:0]   vld;
  logic [NS:0]     rdy;
  logic [NS-1:0]   vin;
  logic [NS-1:0]   ld;
  div_t            dv [0:DIV_STAGES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cone: 1'b1, y2012: 1'b1, sim: 1'b0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CONE: cfg.cone  <= cfg_data;
        REG_2012: cfg.y2012 <= cfg_data;
        REG_SIM:  cfg.sim   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.charged = s_tdata[15:0];
  assign item.neutral = s_tdata[31:16];
  assign item.photon  = s_tdata[47:32];
  assign item.pt      = s_tdata[63:48];
  assign item.eta     = s_tdata[76:64];
  assign item.rho     = s_tdata[92:77];

  always_comb begin
    rdy[NS] = m_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vin = {vld[NS-2:0], s_tvalid};
  assign ld  = rdy[NS-1:0] & vin;
  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld[k] <= vin[k];
      end
    end
  end

  erci_front u_front (
    .clk  (clk),
    .load (ld[FRONT_STAGES-1:0]),
    .din  (item),
    .cfg  (cfg),
    .dout (dv[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    erci_div_stage u_div (
      .clk  (clk),
      .load (ld[FRONT_STAGES+g]),
      .din  (dv[g]),
      .dout (dv[g+1])
    );
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = (dv[DIV_STAGES].zero || dv[DIV_STAGES].sat) ? 16'hFFFF
                                                                 : dv[DIV_STAGES].quo;
  assign m_tuser  = {dv[DIV_STAGES].zero, dv[DIV_STAGES].sat};

endmodule

FILE: rtl/erci_checker.sv
// port-level checks for the rho corrected isolation top level
`include "assert_macros.svh"

module erci_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // zero momentum forces maximum and clears the overflow flag
  `ASSERT_IMPLIES(a_zero_max, clk, rst, m_tvalid && m_tuser[1], m_tdata == 16'hFFFF && !m_tuser[0])

  // overflow always clamps to maximum
  `ASSERT_IMPLIES(a_sat_max, clk, rst, m_tvalid && m_tuser[0], m_tdata == 16'hFFFF)

  // a stalled transaction keeps its payload
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // nothing leaves the pipeline right after reset
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !m_tvalid)

endmodule

bind electron_rho_corrected_isolation_top erci_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: verif/tb.sv
// testbench for the rho corrected electron isolation pipeline
`timescale 1ns / 1ps

module tb;
  import erci_pkg::*;

  typedef struct packed {
    logic [15:0] rel_iso;
    logic        sat;
    logic        zero_pt;
  } iso_result_t;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 16;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // charged_iso, neutral_iso, photon_iso,
                               // transverse_momentum, cluster_eta, event_density, pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // relative_iso
  logic [1:0]  m_tuser;        // saturated, zero_momentum
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;

  iso_result_t iso_expected_q[$];
  cfg_t        area_cfg;
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  electron_rho_corrected_isolation_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** electron_rho_corrected_isolation_top: FAILED **");
    $finish;
  end

  function automatic int unsigned area_thousandths(input int unsigned abs_eta,
                                                   input cfg_t c);
    int unsigned bin;
    int unsigned a12, asim, adat;
    bin = (abs_eta >= 1000) + (abs_eta >= 1479) + (abs_eta >= 2000) +
          (abs_eta >= 2200) + (abs_eta >= 2300) + (abs_eta >= 2400);
    case (bin)
      0: begin a12 = 130; asim = 110; adat = 100; end
      1: begin a12 = 140; asim = 130; adat = 120; end
      2: begin a12 = 70;  asim = 89;  adat = 85;  end
      3: begin a12 = 90;  asim = 130; adat = 110; end
      4: begin a12 = 110; asim = 150; adat = 120; end
      5: begin a12 = 110; asim = 160; adat = 120; end
      default: begin a12 = 140; asim = 190; adat = 130; end
    endcase
    if (!c.cone) return 0;
    if (c.y2012) return a12;
    return c.sim ? asim : adat;
  endfunction

  function automatic iso_result_t predict_isolation(input item_t it, input cfg_t c);
    iso_result_t r;
    logic [12:0] eta_bits;
    int unsigned abs_eta;
    longint unsigned pos, sub, num, quo;
    eta_bits = it.eta;
    abs_eta = eta_bits[12] ? 8192 - int'(eta_bits) : int'(eta_bits);
    if (it.pt == 16'd0) begin
      r.rel_iso = 16'hFFFF;
      r.sat = 1'b0;
      r.zero_pt = 1'b1;
      return r;
    end
    pos = (longint'(it.neutral) + longint'(it.photon)) * 1000;
    sub = longint'(it.rho) * area_thousandths(abs_eta, c);
    num = longint'(it.charged) * 1000 + ((pos > sub) ? pos - sub : 0);
    quo = (num * 4096) / (longint'(it.pt) * 1000);
    r.zero_pt = 1'b0;
    if (quo > 65535) begin
      r.rel_iso = 16'hFFFF;
      r.sat = 1'b1;
    end else begin
      r.rel_iso = quo[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic item_t make_electron(input int charged, input int neutral,
                                          input int photon, input int pt,
                                          input int eta, input int rho);
    item_t it;
    it.charged = 16'(charged);
    it.neutral = 16'(neutral);
    it.photon  = 16'(photon);
    it.pt      = 16'(pt);
    it.eta     = 13'(eta);
    it.rho     = 16'(rho);
    return it;
  endfunction

  function automatic int random_sum();
    case ($urandom_range(3))
      0: return $urandom_range(255);
      1: return $urandom_range(4095);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic item_t random_electron();
    int eta, pt, rho, pick;
    int edge_pt [6];
    edge_pt = '{1000, 1479, 2000, 2200, 2300, 2400};
    case ($urandom_range(9))
      6: begin
        pick = edge_pt[$urandom_range(5)] - int'($urandom_range(1));
        eta = $urandom_range(1) ? -pick : pick;
      end
      7: eta = $urandom_range(8191);
      default: eta = int'($urandom_range(6000)) - 3000;
    endcase
    case ($urandom_range(19))
      0: pt = 0;
      1, 2, 3, 4: pt = $urandom_range(1, 64);
      5, 6, 7, 8: pt = $urandom_range(1, 4095);
      default: pt = $urandom_range(65535);
    endcase
    rho = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4095);
    return make_electron(random_sum(), random_sum(), random_sum(), pt, eta, rho);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one transaction on the input stream, with optional idle cycles first
  task automatic send_electron(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it};
    do @(posedge clk); while (!s_tready);
    iso_expected_q.push_back(predict_isolation(it, area_cfg));
  endtask

  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (iso_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CONE: area_cfg.cone  = val;
      REG_2012: area_cfg.y2012 = val;
      REG_SIM:  area_cfg.sim   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_area_cfg(input cfg_t c);
    drain_pipeline();
    write_reg(REG_CONE, c.cone);
    write_reg(REG_2012, c.y2012);
    write_reg(REG_SIM, c.sim);
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    iso_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (iso_expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h/%b", m_tdata, m_tuser));
      end else begin
        want = iso_expected_q.pop_front();
        if (m_tdata !== want.rel_iso)
          report_mismatch($sformatf("relative_iso %h, want %h", m_tdata, want.rel_iso));
        if (m_tuser[0] !== want.sat)
          report_mismatch($sformatf("saturated %b, want %b", m_tuser[0], want.sat));
        if (m_tuser[1] !== want.zero_pt)
          report_mismatch($sformatf("zero_momentum %b, want %b", m_tuser[1], want.zero_pt));
      end
    end
  end

  task automatic test_field_extremes();
    send_electron(make_electron(0, 0, 0, 1, 0, 0));
    send_electron(make_electron(65535, 65535, 65535, 65535, 2999, 65535));
    send_electron(make_electron(65535, 65535, 65535, 1, 0, 0));
    send_electron(make_electron(100, 200, 300, 0, -3000, 1000));
    send_electron(make_electron(0, 0, 0, 0, 0, 0));
    send_electron(make_electron(64, 0, 0, 65535, -1, 65535));
    send_electron(make_electron(8, 1, 1, 64, 500, 65535));
    send_electron(make_electron(4096, 0, 0, 512, 3000, 0));
  endtask

  task automatic test_eta_bins();
    int eta_pt [10];
    eta_pt = '{999, 1000, -1000, 1478, 1479, 2000, 2299, 2400, -4096, 4095};
    foreach (eta_pt[k])
      send_electron(make_electron(50, 3000, 2000, 640, eta_pt[k], 8000));
  endtask

  task automatic test_area_tables();
    cfg_t c;
    drain_pipeline();
    write_reg(REG_UNUSED, 1'b1);
    for (int k = 0; k < 8; k++) begin
      c = cfg_t'(k);
      write_area_cfg(c);
      send_electron(make_electron(10, 4000, 1000, 320, 2100 + 50 * k, 12000));
    end
  endtask

  task automatic test_random_stream();
    cfg_t c;
    for (int blk = 0; blk < 33; blk++) begin
      c = (blk < 8) ? cfg_t'(blk) : cfg_t'($urandom_range(7));
      write_area_cfg(c);
      if (blk < 11) begin
        send_idle_pct = 9;
        recv_idle_pct = 51;
      end else if (blk < 22) begin
        send_idle_pct = 51;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (50) send_electron(random_electron());
    end
  endtask

  initial begin
    area_cfg.cone  = 1'b1;
    area_cfg.y2012 = 1'b1;
    area_cfg.sim   = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 51;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_eta_bins();
    test_area_tables();
    test_random_stream();
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("** electron_rho_corrected_isolation_top: PASSED **");
    end else begin
      $display("** electron_rho_corrected_isolation_top: FAILED **");
    end
    $finish;
  end

endmodule
